### hdl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and codes of the min-heap priority queue
// Operation and status codes, fixed port widths and the cell control types.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_IN_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic ins;  // place the new key, shift larger keys one cell right
        logic rem;  // drop the head, shift every key one cell left
    } t_cell_cmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic valid;  // cell holds a key
        logic le;     // cell holds a key not larger than the new key
    } t_link;

endpackage

`default_nettype wire

### hdl/mhpq_if.sv
// ----------------------------------------------------------------------------
// mhpq_if: request and response channels of the priority queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhpq_req_if
    import mhpq_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [KEY_IN_W-1:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface mhpq_rsp_if
    import mhpq_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [KEY_IN_W-1:0] min_value;
    logic [STATUS_W-1:0]        status;
    logic [OCC_W-1:0]           occupancy;

    modport source (output valid, output min_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input min_value, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

### hdl/min_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue: priority queue of signed keys, minimum first
// Keys sit in a row of cells kept in ascending order; every insert or removal
// updates all cells at once from their own key and their neighbors' keys.
// ----------------------------------------------------------------------------
// Response: registered, offered in the cycle after the request beat.
// Throughput: one operation per cycle while no response is held back, set by the
//   single compare-and-shift step that every cell performs per operation.
// Reset: clears the key count, all cell valid bits and the response valid flag;
//   the queue is empty and ready as soon as reset is released.
`default_nettype none

module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY  = 128,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mhpq_req_if.sink    i_req,
    mhpq_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KEY_WIDTH-1:0] w_key [CAPACITY];
    t_link                       w_link [CAPACITY];
    logic [CAPACITY-1:0]         w_valid_vec;

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_out_valid;
    logic signed [KEY_IN_W-1:0]  r_min;
    logic [STATUS_W-1:0]         r_status;
    logic [OCC_W-1:0]            r_occ;
    logic signed [KEY_IN_W-1:0]  n_min;
    logic [STATUS_W-1:0]         n_status;

    logic                        w_acc;
    logic                        w_full;
    logic                        w_empty;
    logic                        w_is_rem;
    logic signed [KEY_WIDTH-1:0] w_new_key;
    t_cell_cmd                   w_cmd;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_is_rem    = (i_req.operation == OP_EXTRACT) || (i_req.operation == OP_DELETE);
    assign w_new_key   = KEY_WIDTH'(i_req.key);

    always_comb begin
        w_cmd.ins = w_acc && (i_req.operation == OP_INSERT) && !w_full;
        w_cmd.rem = w_acc && w_is_rem && !w_empty;
    end

    always_comb begin
        n_count  = r_count;
        n_min    = '0;
        n_status = ST_OK;
        case (i_req.operation)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_PEEK, OP_EXTRACT, OP_DELETE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    if (i_req.operation != OP_DELETE) begin
                        n_min = KEY_IN_W'(w_key[0]);
                    end
                    if (w_is_rem) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // row of cells, head (minimum) at index 0
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_link                       w_prev_link;
        logic signed [KEY_WIDTH-1:0] w_prev_key;
        logic                        w_next_valid;
        logic signed [KEY_WIDTH-1:0] w_next_key;

        if (gi == 0) begin : g_head
            assign w_prev_link = '{valid: 1'b1, le: 1'b1};
            assign w_prev_key  = w_new_key;
        end else begin : g_body
            assign w_prev_link = w_link[gi-1];
            assign w_prev_key  = w_key[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_key   = w_key[gi];
        end else begin : g_inner
            assign w_next_valid = w_link[gi+1].valid;
            assign w_next_key   = w_key[gi+1];
        end

        mhpq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_new_key    (w_new_key),
            .i_prev_link  (w_prev_link),
            .i_prev_key   (w_prev_key),
            .i_next_valid (w_next_valid),
            .i_next_key   (w_next_key),
            .o_link       (w_link[gi]),
            .o_key        (w_key[gi])
        );

        assign w_valid_vec[gi] = w_link[gi].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the response payload until the next accepted request
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_min    <= n_min;
            r_status <= n_status;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.min_value = r_min;
    assign o_rsp.status    = r_status;
    assign o_rsp.occupancy = r_occ;

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == r_count)
        else $error("key count differs from number of occupied cells");

    a_head_is_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[1].valid |-> (w_link[0].valid && (w_key[0] <= w_key[1])))
        else $error("head cell does not hold the minimum");

    a_remove_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rem |=> (r_count == $past(r_count) - CW'(1)))
        else $error("removal did not drop exactly one key");

    a_full_only_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (n_status == ST_FULL)) |-> (r_count == CW'(CAPACITY)))
        else $error("full status reported below capacity");

    a_no_change_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> (r_count == $past(r_count)))
        else $error("key count changed without a request beat");

endmodule

`default_nettype wire

### hdl/mhpq_cell.sv
// ----------------------------------------------------------------------------
// mhpq_cell: one slot of the sorted key row
// Holds one key; on insert keeps, takes the new key or takes the left key;
// on removal takes the right neighbor's key.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_cell
    import mhpq_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cell_cmd                   i_cmd,
    input  wire logic signed [KEY_WIDTH-1:0] i_new_key,
    input  wire t_link                       i_prev_link,
    input  wire logic signed [KEY_WIDTH-1:0] i_prev_key,
    input  wire logic                        i_next_valid,
    input  wire logic signed [KEY_WIDTH-1:0] i_next_key,
    output t_link                            o_link,
    output logic signed [KEY_WIDTH-1:0]      o_key
);

    logic                        r_valid;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic                        n_valid;
    logic signed [KEY_WIDTH-1:0] n_key;
    logic                        w_le;

    assign w_le = r_valid && (r_key <= i_new_key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (i_cmd.ins) begin
            n_valid = r_valid | i_prev_link.valid;
            if (!w_le) begin
                // the new key lands right after the last key not above it
                n_key = i_prev_link.le ? i_new_key : i_prev_key;
            end
        end else if (i_cmd.rem) begin
            n_valid = i_next_valid;
            n_key   = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_link = '{valid: r_valid, le: w_le};
    assign o_key  = r_key;

endmodule

`default_nettype wire

### bench/tb_mhpq_checker.sv
// ----------------------------------------------------------------------------
// tb_mhpq_checker: response checker of the min-heap priority queue
// Watches the request and response channels, keeps its own min-heap of the
// accepted keys, and compares every response beat field by field with the
// oldest predicted answer.
// ----------------------------------------------------------------------------
module tb_mhpq_checker
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mhpq_req_if  i_req,
    mhpq_rsp_if  i_rsp,
    output int   o_mismatches,
    output int   o_outstanding
);

    typedef struct packed {
        logic signed [KEY_IN_W-1:0] min_value;
        logic [STATUS_W-1:0]        status;
        logic [OCC_W-1:0]           occupancy;
    } t_heap_answer;

    t_heap_answer               answers [$];
    t_heap_answer               want;
    logic signed [KEY_IN_W-1:0] heap_keys [1:CAPACITY];
    int                         key_count = 0;
    int                         mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic t_heap_answer apply_request(input logic [OP_W-1:0] op,
                                                   input logic signed [KEY_IN_W-1:0] key);
        t_heap_answer               ans;
        int                         pos;
        int                         best;
        int                         lc;
        int                         rc;
        logic signed [KEY_IN_W-1:0] tmp;
        ans.min_value = '0;
        ans.status    = ST_OK;
        if (op == OP_INSERT) begin
            if (key_count >= CAPACITY) begin
                ans.status = ST_FULL;
            end else begin
                key_count++;
                pos = key_count;
                while (pos > 1 && heap_keys[pos / 2] > key) begin
                    heap_keys[pos] = heap_keys[pos / 2];
                    pos = pos / 2;
                end
                heap_keys[pos] = key;
            end
        end else if (key_count == 0) begin
            ans.status = ST_EMPTY;
        end else begin
            if (op == OP_PEEK || op == OP_EXTRACT) begin
                ans.min_value = heap_keys[1];
            end
            if (op == OP_EXTRACT || op == OP_DELETE) begin
                // move the last entry to the root, sift down toward the smaller child
                heap_keys[1] = heap_keys[key_count];
                key_count--;
                pos = 1;
                forever begin
                    best = pos;
                    lc   = 2 * pos;
                    rc   = lc + 1;
                    if (lc <= key_count && heap_keys[lc] < heap_keys[best]) best = lc;
                    if (rc <= key_count && heap_keys[rc] < heap_keys[best]) best = rc;
                    if (best == pos) break;
                    tmp             = heap_keys[pos];
                    heap_keys[pos]  = heap_keys[best];
                    heap_keys[best] = tmp;
                    pos             = best;
                end
            end
        end
        ans.occupancy = key_count[OCC_W-1:0];
        return ans;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_count = 0;
            answers.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                answers.push_back(apply_request(i_req.operation, i_req.key));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (answers.size() == 0) begin
                    report_mismatch($sformatf("response beat with nothing outstanding, status %0d",
                                              i_rsp.status));
                end else begin
                    want = answers.pop_front();
                    if (i_rsp.min_value !== want.min_value) begin
                        report_mismatch($sformatf("min_value %0d, predicted %0d",
                                                  i_rsp.min_value, want.min_value));
                    end
                    if (i_rsp.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  i_rsp.status, want.status));
                    end
                    if (i_rsp.occupancy !== want.occupancy) begin
                        report_mismatch($sformatf("occupancy %0d, predicted %0d",
                                                  i_rsp.occupancy, want.occupancy));
                    end
                end
            end
        end
        o_outstanding <= answers.size();
    end

endmodule

### bench/tb_min_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue: testbench of the min-heap priority queue
// Drives a directed run through empty-queue removals, extreme and repeated
// keys, then long random runs that alternate fill and drain bias so that the
// queue reaches both full and empty, under three idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue;
    import mhpq_pkg::*;

    localparam int CAPACITY     = 128;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   mismatches;
    int   outstanding;

    mhpq_req_if req_ch ();
    mhpq_rsp_if rsp_ch ();

    min_heap_priority_queue #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_IN_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tb_mhpq_checker #(
        .CAPACITY (CAPACITY)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [KEY_IN_W-1:0] pick_key();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'sh8000_0001;
                    3:       return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            // narrow range: many duplicates and equal children
            1, 2, 3: return $signed($urandom_range(16)) - 32'sd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic signed [KEY_IN_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= key;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // hold the sender until every predicted answer has come back
    task automatic wait_for_answers();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int fill_items);
        int              left;
        int              seg;
        int              ins_pct;
        logic [OP_W-1:0] op;
        left = count;
        while (left > 0) begin
            if (fill_items > 0) begin
                seg        = fill_items;
                ins_pct    = 92;
                fill_items = 0;
            end else begin
                seg = $urandom_range(200, 30);
                case ($urandom_range(2))
                    0:       ins_pct = 85;
                    1:       ins_pct = 15;
                    default: ins_pct = 50;
                endcase
            end
            if (seg > left) seg = left;
            repeat (seg) begin
                if ($urandom_range(99) < ins_pct) begin
                    op = OP_INSERT;
                end else begin
                    case ($urandom_range(2))
                        0:       op = OP_PEEK;
                        1:       op = OP_EXTRACT;
                        default: op = OP_DELETE;
                    endcase
                end
                send_item(op, pick_key());
            end
            left -= seg;
        end
    endtask

    initial begin
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_INSERT;
        req_ch.key       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // removals on an empty queue
        send_item(OP_PEEK, 32'sd0);
        send_item(OP_EXTRACT, 32'sh7fff_ffff);
        send_item(OP_DELETE, -32'sd1);
        // extreme and repeated keys
        send_item(OP_INSERT, 32'sh7fff_ffff);
        send_item(OP_INSERT, 32'sh8000_0000);
        send_item(OP_INSERT, 32'sd0);
        send_item(OP_INSERT, -32'sd1);
        send_item(OP_INSERT, 32'sh8000_0001);
        send_item(OP_INSERT, 32'sd5);
        send_item(OP_INSERT, 32'sd5);
        send_item(OP_INSERT, -32'sd1);
        send_item(OP_PEEK, 32'sh1234_5678);
        send_item(OP_EXTRACT, 32'sd0);
        send_item(OP_EXTRACT, 32'sd0);
        send_item(OP_DELETE, 32'sd0);
        send_item(OP_PEEK, 32'sd0);
        send_item(OP_EXTRACT, 32'sd0);
        send_item(OP_INSERT, 32'sd3);
        send_item(OP_INSERT, 32'sd3);
        send_item(OP_INSERT, 32'sd3);
        send_item(OP_EXTRACT, 32'sd0);
        send_item(OP_PEEK, 32'sd0);
        wait_for_answers();

        send_idle_pct  = 32;
        recv_stall_pct = 46;
        run_random(PHASE_ITEMS, 220);
        wait_for_answers();

        send_idle_pct  = 46;
        recv_stall_pct = 32;
        run_random(PHASE_ITEMS, 0);
        wait_for_answers();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_ITEMS - 2 * PHASE_ITEMS, 0);
        wait_for_answers();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_min_heap_priority_queue: clean");
        end else begin
            $display("tb_min_heap_priority_queue: errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_min_heap_priority_queue: errors");
        $finish;
    end

endmodule

### filelist.f
hdl/mhpq_pkg.sv
hdl/mhpq_if.sv
hdl/mhpq_cell.sv
hdl/min_heap_priority_queue.sv
bench/tb_mhpq_checker.sv
bench/tb_min_heap_priority_queue.sv
